// File: rtl/atpr_pkg.sv
// Package for the affine tile-map pixel renderer.
// Holds field widths, command, register and repeat-mode codes and the scroll clip helper.
// No dependencies.
`timescale 1ns / 1ps

package atpr_pkg;

  localparam int MEMORY_WORDS_DEF = 16384;
  localparam int SCREEN_WIDTH     = 256;
  localparam int ADDR_W           = 14;
  localparam int CFG_INDEX_W      = 3;
  localparam int CFG_DATA_W       = 32;

  // func field
  localparam logic FUNC_WRITE = 1'b0;
  localparam logic FUNC_PIXEL = 1'b1;

  // configuration register indexes
  localparam logic [CFG_INDEX_W-1:0] CFG_MATRIX_A   = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_MATRIX_B   = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_MATRIX_C   = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] CFG_MATRIX_D   = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] CFG_CENTER     = 3'd4;
  localparam logic [CFG_INDEX_W-1:0] CFG_SCROLL     = 3'd5;
  localparam logic [CFG_INDEX_W-1:0] CFG_MODE       = 3'd6;
  localparam logic [CFG_INDEX_W-1:0] CFG_LAYER_POS  = 3'd7;

  // repeat modes with special out-of-map handling
  localparam logic [1:0] REPEAT_TILE0 = 2'd2;
  localparam logic [1:0] REPEAT_CLEAR = 2'd3;

  localparam logic [7:0] VFLIP_BASE = 8'd223;

  // keep bits 9:0, bit 13 carries weight -1024
  function automatic logic signed [10:0] clip10(input logic [16:0] v);
    clip10 = $signed({v[13], v[9:0]});
  endfunction

endpackage

// File: rtl/affine_tilemap_pixel_renderer.sv
// Affine tile-map pixel renderer, top level.
// Depends on atpr_pkg; holds the six-stage pixel pipeline and the video memory.
//
// One item (pixel request or memory word write) is taken per clock while in_ready is high;
// each item passes through the pipeline stages: offset setup, four 16x12 multiplies, sum and
// shift, tile-map read, pattern read, color/layer select into the output register. The
// memory has two registered read ports (tile byte, then pixel byte) and one write port.
// Stages advance independently, so bubbles collapse and a held output stalls only the
// stages behind it. Writes land in issue order relative to pixel reads.
// Only pixels with a nonzero color produce a result transfer.
`timescale 1ns / 1ps

module affine_tilemap_pixel_renderer #(
  parameter int MEMORY_WORDS = atpr_pkg::MEMORY_WORDS_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_wr_en,
  input  logic [atpr_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  logic [atpr_pkg::CFG_DATA_W-1:0]     cfg_wdata,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic                                in_func,
  input  logic [atpr_pkg::ADDR_W-1:0]         in_write_addr,
  input  logic [15:0]                         in_write_data,
  input  logic [7:0]                          in_scanline,
  input  logic [7:0]                          in_column,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [7:0]                          out_screen_column,
  output logic [7:0]                          out_color_index,
  output logic [7:0]                          out_layer_position
);

  localparam int AW = $clog2(MEMORY_WORDS);

  // configuration
  logic signed [15:0] matrix_a_r, matrix_b_r, matrix_c_r, matrix_d_r;
  logic [31:0]        center_pair_r, scroll_pair_r;
  logic [4:0]         mode_flags_r;
  logic [23:0]        layer_positions_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      matrix_a_r        <= '0;
      matrix_b_r        <= '0;
      matrix_c_r        <= '0;
      matrix_d_r        <= '0;
      center_pair_r     <= '0;
      scroll_pair_r     <= '0;
      mode_flags_r      <= '0;
      layer_positions_r <= '0;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        atpr_pkg::CFG_MATRIX_A:  matrix_a_r        <= cfg_wdata[15:0];
        atpr_pkg::CFG_MATRIX_B:  matrix_b_r        <= cfg_wdata[15:0];
        atpr_pkg::CFG_MATRIX_C:  matrix_c_r        <= cfg_wdata[15:0];
        atpr_pkg::CFG_MATRIX_D:  matrix_d_r        <= cfg_wdata[15:0];
        atpr_pkg::CFG_CENTER:    center_pair_r     <= cfg_wdata;
        atpr_pkg::CFG_SCROLL:    scroll_pair_r     <= cfg_wdata;
        atpr_pkg::CFG_MODE:      mode_flags_r      <= cfg_wdata[4:0];
        atpr_pkg::CFG_LAYER_POS: layer_positions_r <= cfg_wdata[23:0];
        default: ;
      endcase
    end
  end

  logic signed [15:0] cx, cy, hs, vs;
  logic [1:0]         repeat_mode;
  logic               vflip, hflip, ext_mode;

  assign cx          = $signed(center_pair_r[15:0]);
  assign cy          = $signed(center_pair_r[31:16]);
  assign hs          = $signed(scroll_pair_r[15:0]);
  assign vs          = $signed(scroll_pair_r[31:16]);
  assign repeat_mode = mode_flags_r[1:0];
  assign vflip       = mode_flags_r[2];
  assign hflip       = mode_flags_r[3];
  assign ext_mode    = mode_flags_r[4];

  // stage valids and enables
  logic v1_r, v2_r, v3_r, v4_r, v5_r, v6_r;
  logic en1, en2, en3, en4, en5, en6;

  assign en6      = !v6_r || out_ready;
  assign en5      = !v5_r || en6;
  assign en4      = !v4_r || en5;
  assign en3      = !v3_r || en4;
  assign en2      = !v2_r || en3;
  assign en1      = !v1_r || en2;
  assign in_ready = en1;

  // stage 1: offsets
  logic signed [10:0] hclip, vclip;
  logic signed [8:0]  yline;
  logic signed [11:0] xx_nxt, yy_nxt;

  assign hclip  = atpr_pkg::clip10(17'({hs[15], hs} - {cx[15], cx}));
  assign vclip  = atpr_pkg::clip10(17'({vs[15], vs} - {cy[15], cy}));
  assign yline  = vflip ? $signed({1'b0, atpr_pkg::VFLIP_BASE} - {1'b0, in_scanline})
                        : $signed({1'b0, in_scanline});
  assign xx_nxt = {hclip[10], hclip} + $signed({4'b0, in_column});
  assign yy_nxt = {hclip[10] & 1'b0 | vclip[10], vclip} + {{3{yline[8]}}, yline};

  logic                      s1_func_r;
  logic [atpr_pkg::ADDR_W-1:0] s1_waddr_r;
  logic [15:0]               s1_wdata_r;
  logic [7:0]                s1_col_r;
  logic signed [11:0]        s1_xx_r, s1_yy_r;

  always_ff @(posedge clk) begin
    if (en1) begin
      s1_func_r  <= in_func;
      s1_waddr_r <= in_write_addr;
      s1_wdata_r <= in_write_data;
      s1_col_r   <= in_column;
      s1_xx_r    <= xx_nxt;
      s1_yy_r    <= yy_nxt;
    end
  end

  // stage 2: products
  logic signed [27:0]        ax_nxt, by_nxt, cxp_nxt, dy_nxt;
  logic                      s2_func_r;
  logic [atpr_pkg::ADDR_W-1:0] s2_waddr_r;
  logic [15:0]               s2_wdata_r;
  logic [7:0]                s2_col_r;
  logic signed [27:0]        s2_ax_r, s2_by_r, s2_cx_r, s2_dy_r;

  assign ax_nxt  = matrix_a_r * s1_xx_r;
  assign by_nxt  = matrix_b_r * s1_yy_r;
  assign cxp_nxt = matrix_c_r * s1_xx_r;
  assign dy_nxt  = matrix_d_r * s1_yy_r;

  always_ff @(posedge clk) begin
    if (en2) begin
      s2_func_r  <= s1_func_r;
      s2_waddr_r <= s1_waddr_r;
      s2_wdata_r <= s1_wdata_r;
      s2_col_r   <= s1_col_r;
      s2_ax_r    <= ax_nxt;
      s2_by_r    <= by_nxt;
      s2_cx_r    <= cxp_nxt;
      s2_dy_r    <= dy_nxt;
    end
  end

  // stage 3: sums, floor divide by 256
  logic signed [29:0]        sum_x, sum_y;
  logic                      s3_func_r;
  logic [atpr_pkg::ADDR_W-1:0] s3_waddr_r;
  logic [15:0]               s3_wdata_r;
  logic [7:0]                s3_col_r;
  logic [21:0]               s3_px_r, s3_py_r;

  assign sum_x = {{2{s2_ax_r[27]}}, s2_ax_r} + {{2{s2_by_r[27]}}, s2_by_r}
               + {{6{cx[15]}}, cx, 8'b0};
  assign sum_y = {{2{s2_cx_r[27]}}, s2_cx_r} + {{2{s2_dy_r[27]}}, s2_dy_r}
               + {{6{cy[15]}}, cy, 8'b0};

  always_ff @(posedge clk) begin
    if (en3) begin
      s3_func_r  <= s2_func_r;
      s3_waddr_r <= s2_waddr_r;
      s3_wdata_r <= s2_wdata_r;
      s3_col_r   <= s2_col_r;
      s3_px_r    <= sum_x[29:8];
      s3_py_r    <= sum_y[29:8];
    end
  end

  // stage 4: map check, tile read; memory writes commit here
  logic                      outside;
  logic [atpr_pkg::ADDR_W-1:0] tile_addr, color_addr;
  logic                      s4_pix_r, s4_clear_r;
  logic [7:0]                s4_col_r;
  logic [2:0]                s4_px_r, s4_py_r;
  logic [7:0]                s4_tile_r;
  logic                      s5_pix_r;
  logic [7:0]                s5_col_r;
  logic [7:0]                s5_color_r;

  assign outside   = (s3_px_r[21:10] != '0) || (s3_py_r[21:10] != '0);
  assign tile_addr = (repeat_mode == atpr_pkg::REPEAT_TILE0 && outside) ? '0
                   : {s3_py_r[9:3], s3_px_r[9:3]};

  always_ff @(posedge clk) begin
    if (en4) begin
      s4_pix_r   <= s3_func_r == atpr_pkg::FUNC_PIXEL;
      s4_clear_r <= repeat_mode == atpr_pkg::REPEAT_CLEAR && outside;
      s4_col_r   <= s3_col_r;
      s4_px_r    <= s3_px_r[2:0];
      s4_py_r    <= s3_py_r[2:0];
    end
  end

  // stage 5: pattern read
  assign color_addr = {s4_tile_r, s4_py_r, s4_px_r};

  logic [15:0] video_mem [MEMORY_WORDS];

  always_ff @(posedge clk) begin
    if (en4 && v3_r && s3_func_r == atpr_pkg::FUNC_WRITE) begin
      video_mem[AW'(s3_waddr_r)] <= s3_wdata_r;
    end
    if (en4) begin
      s4_tile_r <= video_mem[AW'(tile_addr)][7:0];
    end
    if (en5) begin
      s5_color_r <= video_mem[AW'(color_addr)][15:8];
    end
  end

  always_ff @(posedge clk) begin
    if (en5) begin
      s5_pix_r <= s4_pix_r && !s4_clear_r;
      s5_col_r <= s4_col_r;
    end
  end

  // stage 6: color and layer select, output register
  logic [7:0] color_sel, pos_sel, scol_sel;
  logic       hit;

  assign color_sel = ext_mode ? {1'b0, s5_color_r[6:0]} : s5_color_r;
  assign pos_sel   = !ext_mode    ? layer_positions_r[7:0]
                   : s5_color_r[7] ? layer_positions_r[23:16]
                   :                 layer_positions_r[15:8];
  assign scol_sel  = hflip ? 8'(atpr_pkg::SCREEN_WIDTH - 1) - s5_col_r : s5_col_r;
  assign hit       = v5_r && s5_pix_r && (color_sel != '0);

  always_ff @(posedge clk) begin
    if (en6) begin
      out_screen_column  <= scol_sel;
      out_color_index    <= color_sel;
      out_layer_position <= pos_sel;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
      v5_r <= 1'b0;
      v6_r <= 1'b0;
    end else begin
      if (en1) v1_r <= in_valid;
      if (en2) v2_r <= v1_r;
      if (en3) v3_r <= v2_r;
      if (en4) v4_r <= v3_r;
      if (en5) v5_r <= v4_r;
      if (en6) v6_r <= hit;
    end
  end

  assign out_valid = v6_r;

endmodule

// File: tb/sv/affine_tilemap_pixel_renderer_test.sv
// Self-checking testbench for the affine tile-map pixel renderer: directed corner pixels, then
// random register settings with mixed pixel requests and memory word writes, random idling.
// Depends on atpr_pkg and affine_tilemap_pixel_renderer; words are written before first read.
`timescale 1ns / 1ps

module affine_tilemap_pixel_renderer_test;

  localparam int LIMIT_CYCLES = 5_000_000;
  localparam int DRAIN_LIMIT  = 4000;
  localparam int PIPE_SLACK   = 16;
  localparam int RAND_PHASES  = 8;
  localparam int RAND_ITEMS   = 230;
  localparam int MODE_VFLIP   = 2;
  localparam int MODE_HFLIP   = 3;
  localparam int MODE_EXT     = 4;

  typedef struct packed {
    logic        func;
    logic [13:0] addr;
    logic [15:0] data;
    logic [7:0]  line;
    logic [7:0]  col;
  } render_req_t;

  typedef struct packed {
    logic [7:0] scol;
    logic [7:0] color;
    logic [7:0] pos;
  } pixel_out_t;

  logic                             clk = 1'b0;
  logic                             rst_n = 1'b0;
  logic                             cfg_wr_en = 1'b0;
  logic [atpr_pkg::CFG_INDEX_W-1:0] cfg_index = '0;
  logic [atpr_pkg::CFG_DATA_W-1:0]  cfg_wdata = '0;
  logic                             in_valid = 1'b0;
  logic                             in_ready;
  logic                             in_func = 1'b0;
  logic [atpr_pkg::ADDR_W-1:0]      in_write_addr = '0;
  logic [15:0]                      in_write_data = '0;
  logic [7:0]                       in_scanline = '0;
  logic [7:0]                       in_column = '0;
  logic                             out_valid;
  logic                             out_ready = 1'b0;
  logic [7:0]                       out_screen_column;
  logic [7:0]                       out_color_index;
  logic [7:0]                       out_layer_position;

  // shadow of the block's registers and video memory
  logic [15:0] coef_a, coef_b, coef_c, coef_d;
  logic [31:0] center_reg, scroll_reg;
  logic [4:0]  mode_reg;
  logic [23:0] layer_reg;
  logic [15:0] shadow_vram [atpr_pkg::MEMORY_WORDS_DEF];

  // memory contents as seen by the stimulus generator, ahead of the transfers
  logic [15:0] gen_vram [atpr_pkg::MEMORY_WORDS_DEF];
  bit          gen_written [atpr_pkg::MEMORY_WORDS_DEF];

  render_req_t request_fifo[$];
  pixel_out_t  due_pixels[$];
  render_req_t cur_req;

  int queued_count = 0;
  int taken_count = 0;
  int pixel_count = 0;
  int write_count = 0;
  int dark_count = 0;
  int checked_count = 0;
  int setting_count = 0;
  int fault_count = 0;
  int in_gap = 0;
  int out_hold = 0;
  bit in_quiet = 1'b0;
  bit out_quiet = 1'b0;
  longint cycle_count = 0;

  affine_tilemap_pixel_renderer u_dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg_wr_en          (cfg_wr_en),
    .cfg_index          (cfg_index),
    .cfg_wdata          (cfg_wdata),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_func            (in_func),
    .in_write_addr      (in_write_addr),
    .in_write_data      (in_write_data),
    .in_scanline        (in_scanline),
    .in_column          (in_column),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_screen_column  (out_screen_column),
    .out_color_index    (out_color_index),
    .out_layer_position (out_layer_position)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= LIMIT_CYCLES) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("TEST FAILED");
      $finish;
    end
  end

  function automatic int pick_gap(input bit quiet);
    int r;
    r = $urandom_range(0, 99);
    if (quiet || r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic longint clip_scroll(input longint v);
    return longint'(v[9:0]) - (v[13] ? 64'sd1024 : 64'sd0);
  endfunction

  task automatic note_fault(input string msg);
    fault_count++;
    if (fault_count <= 10) $display("MISMATCH: %s", msg);
  endtask

  // map coordinates of a pixel under the current register settings
  task automatic calc_coords(input logic [7:0] line, input logic [7:0] col,
                             output longint px, output longint py);
    longint cx, cy, hs, vs, xx, yy;
    cx = $signed(center_reg[15:0]);
    cy = $signed(center_reg[31:16]);
    hs = $signed(scroll_reg[15:0]);
    vs = $signed(scroll_reg[31:16]);
    yy = mode_reg[MODE_VFLIP] ? longint'(atpr_pkg::VFLIP_BASE) - longint'(line)
                              : longint'(line);
    yy = yy + clip_scroll(vs - cy);
    xx = clip_scroll(hs - cx) + longint'(col);
    px = (longint'($signed(coef_a)) * xx + longint'($signed(coef_b)) * yy + cx * 256) >>> 8;
    py = (longint'($signed(coef_c)) * xx + longint'($signed(coef_d)) * yy + cy * 256) >>> 8;
  endtask

  // applies one accepted transfer to the shadow state; queues the pixel it should produce
  task automatic commit_request(input render_req_t r);
    longint      px, py;
    logic [13:0] map_addr;
    logic [7:0]  tile, color, pos;
    logic [1:0]  wrap_mode;
    bit          off_map;
    pixel_out_t  p;
    if (r.func == atpr_pkg::FUNC_WRITE) begin
      shadow_vram[r.addr] = r.data;
      write_count++;
    end else begin
      pixel_count++;
      calc_coords(r.line, r.col, px, py);
      wrap_mode = mode_reg[1:0];
      off_map = px < 0 || px > 1023 || py < 0 || py > 1023;
      if (wrap_mode == atpr_pkg::REPEAT_CLEAR && off_map) begin
        color = 8'd0;
      end else begin
        if (wrap_mode == atpr_pkg::REPEAT_TILE0 && off_map) map_addr = '0;
        else map_addr = {py[9:3], px[9:3]};
        tile = shadow_vram[map_addr][7:0];
        color = shadow_vram[{tile, py[2:0], px[2:0]}][15:8];
      end
      if (mode_reg[MODE_EXT]) begin
        pos = color[7] ? layer_reg[23:16] : layer_reg[15:8];
        color[7] = 1'b0;
      end else begin
        pos = layer_reg[7:0];
      end
      if (color == 8'd0) begin
        dark_count++;
      end else begin
        p.scol = mode_reg[MODE_HFLIP] ? 8'd255 - r.col : r.col;
        p.color = color;
        p.pos = pos;
        due_pixels.push_back(p);
      end
    end
  endtask

  always @(posedge clk) begin : request_driver
    render_req_t nxt;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        commit_request(cur_req);
        taken_count++;
      end
      if (!in_valid || in_ready) begin
        if (in_gap > 0) begin
          in_gap--;
          in_valid <= 1'b0;
        end else if (request_fifo.size() > 0) begin
          nxt = request_fifo.pop_front();
          cur_req = nxt;
          in_func <= nxt.func;
          in_write_addr <= nxt.addr;
          in_write_data <= nxt.data;
          in_scanline <= nxt.line;
          in_column <= nxt.col;
          in_valid <= 1'b1;
          in_gap = pick_gap(in_quiet);
          if ($urandom_range(0, 99) == 0) in_quiet = !in_quiet;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin : result_monitor
    pixel_out_t exp_p;
    if (rst_n && out_valid && out_ready) begin
      if (due_pixels.size() == 0) begin
        note_fault($sformatf("unexpected pixel col=%0d color=%0d pos=%0d",
                             out_screen_column, out_color_index, out_layer_position));
      end else begin
        exp_p = due_pixels.pop_front();
        checked_count++;
        if (out_screen_column !== exp_p.scol || out_color_index !== exp_p.color ||
            out_layer_position !== exp_p.pos)
          note_fault($sformatf("col exp %0d got %0d, color exp %0d got %0d, pos exp %0d got %0d",
                               exp_p.scol, out_screen_column, exp_p.color, out_color_index,
                               exp_p.pos, out_layer_position));
      end
    end
  end

  always @(posedge clk) begin : result_backpressure
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else if (out_hold > 0) begin
      out_hold--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
      if ($urandom_range(0, 3) == 0) out_hold = pick_gap(out_quiet);
      if ($urandom_range(0, 199) == 0) out_quiet = !out_quiet;
    end
  end

  task automatic push_write(input logic [13:0] addr, input logic [15:0] data);
    render_req_t r;
    r.func = atpr_pkg::FUNC_WRITE;
    r.addr = addr;
    r.data = data;
    r.line = 8'($urandom);
    r.col = 8'($urandom);
    gen_vram[addr] = data;
    gen_written[addr] = 1'b1;
    request_fifo.push_back(r);
    queued_count++;
  endtask

  // writes the map and pattern words the pixel will read, unless they already hold data
  task automatic push_pixel(input logic [7:0] line, input logic [7:0] col);
    render_req_t r;
    longint      px, py;
    logic [13:0] map_addr, pat_addr;
    logic [7:0]  tile;
    bit          off_map;
    calc_coords(line, col, px, py);
    off_map = px < 0 || px > 1023 || py < 0 || py > 1023;
    if (!(mode_reg[1:0] == atpr_pkg::REPEAT_CLEAR && off_map)) begin
      if (mode_reg[1:0] == atpr_pkg::REPEAT_TILE0 && off_map) map_addr = '0;
      else map_addr = {py[9:3], px[9:3]};
      if (!gen_written[map_addr]) push_write(map_addr, rand_word());
      tile = gen_vram[map_addr][7:0];
      pat_addr = {tile, py[2:0], px[2:0]};
      if (!gen_written[pat_addr]) push_write(pat_addr, rand_word());
    end
    r = '0;
    r.func = atpr_pkg::FUNC_PIXEL;
    r.addr = 14'($urandom);
    r.data = 16'($urandom);
    r.line = line;
    r.col = col;
    request_fifo.push_back(r);
    queued_count++;
  endtask

  // low byte tile number, high byte color; zero color often enough to see transparency
  function automatic logic [15:0] rand_word();
    logic [7:0] hi;
    hi = ($urandom_range(0, 4) == 0) ? 8'd0 : 8'($urandom);
    return {hi, 8'($urandom)};
  endfunction

  function automatic logic [15:0] rand_coef();
    int r, s;
    r = $urandom_range(0, 9);
    if (r == 0) return 16'h8000;
    if (r == 1) return 16'h7fff;
    if (r < 7) begin
      s = $urandom_range(0, 1023) - 512;
      return s[15:0];
    end
    return 16'($urandom);
  endfunction

  function automatic logic [15:0] rand_half();
    int r, s;
    r = $urandom_range(0, 5);
    if (r == 0) return 16'h8000;
    if (r == 1) return 16'h7fff;
    if (r < 4) begin
      s = $urandom_range(0, 1023) - 256;
      return s[15:0];
    end
    return 16'($urandom);
  endfunction

  task automatic set_reg(input logic [atpr_pkg::CFG_INDEX_W-1:0] idx, input logic [31:0] val);
    @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    case (idx)
      atpr_pkg::CFG_MATRIX_A:  coef_a = val[15:0];
      atpr_pkg::CFG_MATRIX_B:  coef_b = val[15:0];
      atpr_pkg::CFG_MATRIX_C:  coef_c = val[15:0];
      atpr_pkg::CFG_MATRIX_D:  coef_d = val[15:0];
      atpr_pkg::CFG_CENTER:    center_reg = val;
      atpr_pkg::CFG_SCROLL:    scroll_reg = val;
      atpr_pkg::CFG_MODE:      mode_reg = val[4:0];
      atpr_pkg::CFG_LAYER_POS: layer_reg = val[23:0];
      default: ;
    endcase
  endtask

  // unused upper bits of the write data carry junk, the block must drop them
  task automatic apply_setting(input logic [15:0] a, input logic [15:0] b, input logic [15:0] c,
                               input logic [15:0] d, input logic [31:0] center,
                               input logic [31:0] scroll, input logic [4:0] mode,
                               input logic [23:0] layer);
    logic [31:0] junk;
    junk = $urandom;
    set_reg(atpr_pkg::CFG_MATRIX_A, {junk[15:0], a});
    set_reg(atpr_pkg::CFG_MATRIX_B, {junk[31:16], b});
    set_reg(atpr_pkg::CFG_MATRIX_C, {junk[23:8], c});
    set_reg(atpr_pkg::CFG_MATRIX_D, {junk[27:12], d});
    set_reg(atpr_pkg::CFG_CENTER, center);
    set_reg(atpr_pkg::CFG_SCROLL, scroll);
    set_reg(atpr_pkg::CFG_MODE, {junk[26:0], mode});
    set_reg(atpr_pkg::CFG_LAYER_POS, {junk[31:24], layer});
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    setting_count++;
  endtask

  // wait until every transfer is taken and every expected pixel has come, then let the pipe empty
  task automatic settle();
    int waited;
    waited = 0;
    while (taken_count != queued_count) @(posedge clk);
    while (due_pixels.size() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    if (due_pixels.size() != 0) begin
      note_fault($sformatf("%0d expected pixels never arrived", due_pixels.size()));
      fault_count += due_pixels.size() - 1;
      due_pixels.delete();
    end
    repeat (PIPE_SLACK) @(posedge clk);
  endtask

  initial begin
    int phase_base;
    coef_a = '0;
    coef_b = '0;
    coef_c = '0;
    coef_d = '0;
    center_reg = '0;
    scroll_reg = '0;
    mode_reg = '0;
    layer_reg = '0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // reset register values
    push_pixel(8'd0, 8'd0);
    push_pixel(8'd255, 8'd255);
    settle();

    // identity transform, both flips, extreme write data
    apply_setting(16'h0100, 16'h0000, 16'h0000, 16'h0100, 32'h0, 32'h0,
                  5'b01100, 24'h0000a5);
    push_write(14'h3fff, 16'hffff);
    push_write(14'h0000, 16'h0000);
    push_pixel(8'd0, 8'd0);
    push_pixel(8'd255, 8'd0);
    push_pixel(8'd0, 8'd255);
    push_pixel(8'd223, 8'd128);
    settle();

    // extreme matrix and offsets, off-map pixels use tile entry zero
    apply_setting(16'h7fff, 16'h8000, 16'h8000, 16'h7fff, 32'h8000_7fff, 32'h7fff_8000,
                  {3'b000, atpr_pkg::REPEAT_TILE0}, 24'hffffff);
    push_pixel(8'd0, 8'd0);
    push_pixel(8'd0, 8'd255);
    push_pixel(8'd255, 8'd0);
    push_pixel(8'd255, 8'd255);
    settle();

    // same, off-map pixels transparent, extended priority
    apply_setting(16'h7fff, 16'h8000, 16'h8000, 16'h7fff, 32'h8000_7fff, 32'h7fff_8000,
                  {3'b100, atpr_pkg::REPEAT_CLEAR}, 24'h807f01);
    push_pixel(8'd0, 8'd0);
    push_pixel(8'd0, 8'd255);
    push_pixel(8'd255, 8'd0);
    push_pixel(8'd255, 8'd255);
    settle();

    // clip with bit 13 set in scroll minus center, extended mode, plain wrap
    apply_setting(16'h0100, 16'h0000, 16'h0000, 16'h0100, 32'h0040_0040, 32'h2000_3fff,
                  5'b10001, 24'h3c5a96);
    push_pixel(8'd10, 8'd20);
    push_pixel(8'd200, 8'd100);
    push_pixel(8'd128, 8'd255);
    settle();

    for (int ph = 0; ph < RAND_PHASES; ph++) begin
      apply_setting(rand_coef(), rand_coef(), rand_coef(), rand_coef(),
                    {rand_half(), rand_half()}, {rand_half(), rand_half()},
                    5'($urandom_range(0, 31)), 24'($urandom));
      phase_base = queued_count;
      while (queued_count < phase_base + RAND_ITEMS) begin
        if ($urandom_range(0, 99) < 15) push_write(14'($urandom), rand_word());
        else push_pixel(8'($urandom), 8'($urandom));
      end
      settle();
    end

    $display("Rendered %0d pixel requests and %0d memory writes over %0d register settings.",
             pixel_count, write_count, setting_count + 1);
    $display("Checked %0d colored pixels; %0d were transparent; %0d mismatches.",
             checked_count, dark_count, fault_count);
    if (fault_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
